// File: hdl/dtq_pkg.sv
// Shared types and constants for the deadline timer queue.
package dtq_pkg;

    localparam int TICK_W   = 64;
    localparam int ID_W     = 32;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_REPLY    = 3'd0,
        KIND_CANCEL_REPLY = 3'd1,
        KIND_EXPIRED      = 3'd2,
        KIND_SWEEP_DONE   = 3'd3,
        KIND_EARLIEST     = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CMATCH,
        S_CDROP,
        S_SWEEP,
        S_QUERY
    } t_state;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ADD,
        CELL_MATCH,
        CELL_DROP,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [TICK_W-1:0] tick;
        logic [ID_W-1:0]   id;
    } t_cell_ctl;

    typedef struct packed {
        logic              valid;
        logic [TICK_W-1:0] deadline;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   timer_id_res;
        logic [TICK_W-1:0] tick_res;
        t_status           status;
        logic              last;
    } t_result;

endpackage

// File: hdl/dtq_cmd_if.sv
// Command channel: valid/ready handshake carrying one command item.
interface dtq_cmd_if;
    import dtq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [TICK_W-1:0] tick;
    logic [ID_W-1:0]   timer_id;

    modport source (output valid, output opcode, output tick, output timer_id, input ready);
    modport sink   (input valid, input opcode, input tick, input timer_id, output ready);
endinterface

// File: hdl/dtq_res_if.sv
// Result channel: valid/ready handshake carrying one result item.
interface dtq_res_if;
    import dtq_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     timer_id_res;
    logic [TICK_W-1:0]   tick_res;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output kind, output timer_id_res, output tick_res,
                    output status, output last, input ready);
    modport sink   (input valid, input kind, input timer_id_res, input tick_res,
                    input status, input last, output ready);
endinterface

// File: hdl/dtq_cell.sv
// One slot of the sorted timer chain, talking to its two neighbors and the broadcast control.
module dtq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtq_pkg::t_cell_ctl i_ctl,
    input  dtq_pkg::t_entry    i_left,
    input  logic               i_left_shift,
    input  logic               i_left_hit,
    input  dtq_pkg::t_entry    i_right,
    output dtq_pkg::t_entry    o_entry,
    output logic               o_shift,
    output logic               o_hit
);
    import dtq_pkg::*;

    logic              r_valid;
    logic [TICK_W-1:0] r_deadline;
    logic [ID_W-1:0]   r_id;
    logic              r_match;

    logic              n_valid;
    logic [TICK_W-1:0] n_deadline;
    logic [ID_W-1:0]   n_id;
    logic              n_match;

    // Slot sits at or after the insert point of the new deadline.
    assign o_shift = !r_valid || (r_deadline > i_ctl.tick);
    // First cancel match lies in this slot or an earlier one.
    assign o_hit   = i_left_hit || r_match;

    assign o_entry.valid    = r_valid;
    assign o_entry.deadline = r_deadline;
    assign o_entry.id       = r_id;

    always_comb begin
        n_valid    = r_valid;
        n_deadline = r_deadline;
        n_id       = r_id;
        n_match    = r_match;
        case (i_ctl.op)
            CELL_ADD: begin
                if (o_shift) begin
                    if (i_left_shift && i_left.valid) begin
                        n_valid    = 1'b1;
                        n_deadline = i_left.deadline;
                        n_id       = i_left.id;
                    end else if (!i_left_shift) begin
                        n_valid    = 1'b1;
                        n_deadline = i_ctl.tick;
                        n_id       = i_ctl.id;
                    end
                end
            end
            CELL_MATCH: begin
                n_match = r_valid && (r_id == i_ctl.id) && (r_deadline == i_ctl.tick);
            end
            CELL_DROP: begin
                if (o_hit) begin
                    n_valid    = i_right.valid;
                    n_deadline = i_right.deadline;
                    n_id       = i_right.id;
                end
                n_match = 1'b0;
            end
            CELL_POP: begin
                n_valid    = i_right.valid;
                n_deadline = i_right.deadline;
                n_id       = i_right.id;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deadline <= n_deadline;
        r_id       <= n_id;
    end

endmodule

// File: hdl/deadline_timer_queue.sv
// Add and query answer from their own state after the command item is accepted; cancel first
// passes a match state, then answers from its drop state. Sweep emits one expired timer per cycle
// while the output slot is free, then a done item. A new command is taken only when idle;
// the chain shifts by one slot per popped timer, which sets the sweep rate.
// Reset (synchronous, active low) clears all valid marks, the identity counter and the
// output valid flag; stored deadlines and identities are left as they are.
module deadline_timer_queue #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtq_cmd_if.sink     i_cmd,
    dtq_res_if.source   o_res
);
    import dtq_pkg::*;

    // Controller state and the captured command.
    t_state            r_state;
    t_state            n_state;
    logic [TICK_W-1:0] r_cmd_tick;
    logic [ID_W-1:0]   r_cmd_id;
    logic [ID_W-1:0]   r_id_ctr;
    logic [ID_W-1:0]   w_next_id;
    logic              w_id_inc;

    // Output register between the controller and the result channel.
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              w_out_load;
    logic              w_slot_free;

    // Chain of cells: entries, add shift flags and cancel hit prefix.
    t_cell_ctl         w_ctl;
    t_entry            w_entry [TABLE_DEPTH];
    logic              w_shift [TABLE_DEPTH];
    logic              w_hit   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_valid_vec;
    t_entry            w_none;
    logic              w_full;
    logic              w_head_expired;
    logic              w_found;

    assign w_none      = '0;
    assign w_next_id   = r_id_ctr + 1'b1;
    assign w_slot_free = !r_out_valid || o_res.ready;
    // The chain is compact, so the last slot being valid means the table is full.
    assign w_full      = w_entry[TABLE_DEPTH-1].valid;
    assign w_found     = w_hit[TABLE_DEPTH-1];
    assign w_head_expired = w_entry[0].valid && (w_entry[0].deadline <= r_cmd_tick);

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            dtq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_left       ((g == 0) ? w_none : w_entry[(g == 0) ? 0 : g-1]),
                .i_left_shift ((g == 0) ? 1'b0 : w_shift[(g == 0) ? 0 : g-1]),
                .i_left_hit   ((g == 0) ? 1'b0 : w_hit[(g == 0) ? 0 : g-1]),
                .i_right      ((g == TABLE_DEPTH-1) ? w_none
                                : w_entry[(g == TABLE_DEPTH-1) ? g : g+1]),
                .o_entry      (w_entry[g]),
                .o_shift      (w_shift[g]),
                .o_hit        (w_hit[g])
            );
            assign w_valid_vec[g] = w_entry[g].valid;
        end
    endgenerate

    // Take a new command only when the controller is idle.
    assign i_cmd.ready = (r_state == S_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (t_op'(i_cmd.opcode))
                        OP_ADD:    n_state = S_ADD;
                        OP_CANCEL: n_state = S_CMATCH;
                        OP_SWEEP:  n_state = S_SWEEP;
                        OP_QUERY:  n_state = S_QUERY;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD, S_CDROP, S_QUERY: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            S_CMATCH: n_state = S_CDROP;
            S_SWEEP: begin
                if (w_slot_free && !w_head_expired) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Cell commands and result items.
    always_comb begin
        w_ctl.op   = CELL_HOLD;
        w_ctl.tick = r_cmd_tick;
        w_ctl.id   = r_cmd_id;
        w_id_inc   = 1'b0;
        w_out_load = 1'b0;
        n_out      = '0;
        n_out.last = 1'b1;
        unique case (r_state)
            S_ADD: begin
                n_out.kind = KIND_ADD_REPLY;
                w_ctl.id   = w_next_id;
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    if (w_full) begin
                        // Table full: nothing stored, counter holds.
                        n_out.status = STATUS_FULL;
                    end else begin
                        w_ctl.op           = CELL_ADD;
                        w_id_inc           = 1'b1;
                        n_out.timer_id_res = w_next_id;
                        n_out.tick_res     = r_cmd_tick;
                    end
                end
            end
            S_CMATCH: begin
                // Every cell compares identity and deadline in parallel.
                w_ctl.op = CELL_MATCH;
            end
            S_CDROP: begin
                n_out.kind = KIND_CANCEL_REPLY;
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    w_ctl.op   = CELL_DROP;
                    if (w_found) begin
                        n_out.timer_id_res = r_cmd_id;
                        n_out.tick_res     = r_cmd_tick;
                    end else begin
                        n_out.status = STATUS_NOT_FOUND;
                    end
                end
            end
            S_SWEEP: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    if (w_head_expired) begin
                        // Emit the head and advance the chain by one slot.
                        w_ctl.op           = CELL_POP;
                        n_out.kind         = KIND_EXPIRED;
                        n_out.timer_id_res = w_entry[0].id;
                        n_out.tick_res     = w_entry[0].deadline;
                        n_out.last         = 1'b0;
                    end else begin
                        n_out.kind = KIND_SWEEP_DONE;
                    end
                end
            end
            S_QUERY: begin
                n_out.kind = KIND_EARLIEST;
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    if (w_entry[0].valid) n_out.tick_res = w_entry[0].deadline;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_id_ctr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_id_inc) r_id_ctr <= w_next_id;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd_tick <= i_cmd.tick;
            r_cmd_id   <= i_cmd.timer_id;
        end
        if (w_out_load) r_out <= n_out;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.timer_id_res = r_out.timer_id_res;
    assign o_res.tick_res     = r_out.tick_res;
    assign o_res.status       = r_out.status;
    assign o_res.last         = r_out.last;

    // Valid slots always form a prefix of the chain.
    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec & (w_valid_vec + 1'b1)) == '0)
        else $error("timer chain is not compact");

    // The identity counter only ever steps by one.
    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_id_ctr != $past(r_id_ctr)) |-> (r_id_ctr == $past(r_id_ctr) + 1'b1))
        else $error("identity counter jumped");

    generate
        if (TABLE_DEPTH > 1) begin : g_order_chk
            // Head of the chain holds a deadline no later than the next slot.
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_entry[1].valid |-> (w_entry[0].deadline <= w_entry[1].deadline))
                else $error("timer chain out of deadline order");
        end
    endgenerate

endmodule
